[hdl/cat_pkg.sv]
// ----------------------------------------------------------------------------
// cat_pkg
// Shared types and codes for the card access table.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int KEY_W           = 64;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]       mode;
        logic [KEY_W-1:0] card_id;
        logic             grant_access;
    } cat_in_t;

    typedef struct packed {
        logic [1:0]             status;
        logic                   card_access;
        logic [COUNT_OUT_W-1:0] entry_count;
    } cat_out_t;

    // Broadcast from the controller to every cell during the update cycle
    typedef struct packed {
        logic             exec;
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        logic             grant;
        logic             hit;
        logic             full;
    } cat_cell_ctrl_t;

endpackage

[hdl/cat_cell.sv]
// ----------------------------------------------------------------------------
// cat_cell
// One table entry: key, flag, compare against the request key, and a move
// down from the next cell when an earlier or this entry is removed.
// ----------------------------------------------------------------------------
module cat_cell (
    input  logic                       aclk,
    input  cat_pkg::cat_cell_ctrl_t    ctrl,
    input  logic                       occupied,
    input  logic                       tail,
    input  logic                       found_in,
    input  logic [cat_pkg::KEY_W-1:0]  next_key,
    input  logic                       next_flag,
    output logic [cat_pkg::KEY_W-1:0]  key_q,
    output logic                       flag_q,
    output logic                       here,
    output logic                       found_out
);

    logic [cat_pkg::KEY_W-1:0] key_reg, key_next;
    logic                      flag_reg, flag_next;

    assign here      = occupied && (key_reg == ctrl.key);
    assign found_out = found_in || here;
    assign key_q     = key_reg;
    assign flag_q    = flag_reg;

    always_comb begin
        key_next  = key_reg;
        flag_next = flag_reg;
        if (ctrl.exec) begin
            if (ctrl.mode == cat_pkg::MODE_ADD) begin
                if (here) begin
                    flag_next = ctrl.grant;
                end else if (!ctrl.hit && !ctrl.full && tail) begin
                    key_next  = ctrl.key;
                    flag_next = ctrl.grant;
                end
            end else if (ctrl.mode == cat_pkg::MODE_REMOVE) begin
                // every entry from the removed one upward takes its neighbour's word
                if (found_out) begin
                    key_next  = next_key;
                    flag_next = next_flag;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        flag_reg <= flag_next;
    end

endmodule

[hdl/card_access_table.sv]
// ----------------------------------------------------------------------------
// card_access_table
// Ordered access list of card keys with flags: add/update, remove, lookup.
// ----------------------------------------------------------------------------
//  channel | ports                    | word
//  --------+--------------------------+----------------------------------
//  request | s_valid s_ready s_data   | mode, card_id, grant_access
//  result  | m_valid m_ready m_data   | status, card_access, entry_count
//
//  In IDLE the request word is registered; in EXEC every cell compares
//  in parallel and the row updates (shift-down on remove).
//  The result register frees the input: a new request is taken while a
//  result waits; the update cycle holds until the result register is free.
//  Synchronous active-low reset empties the table (count only).
// ----------------------------------------------------------------------------
module card_access_table #(
    parameter int TABLE_DEPTH = cat_pkg::TABLE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cat_pkg::cat_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cat_pkg::cat_out_t m_data
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                     state_reg, state_next;
    cat_pkg::cat_in_t         req_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     m_valid_reg, m_valid_next;
    cat_pkg::cat_out_t        m_data_reg, m_data_next;

    cat_pkg::cat_cell_ctrl_t  ctrl;
    logic                     exec_fire;
    logic                     hit;
    logic                     full;
    logic                     hit_flag;
    logic [31:0]              count_ext;

    logic [TABLE_DEPTH-1:0]   here_vec;
    logic [TABLE_DEPTH-1:0]   flag_vec;
    logic [TABLE_DEPTH:0]     found_chain;
    logic [cat_pkg::KEY_W-1:0] key_vec [TABLE_DEPTH];

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);
    assign full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign hit       = found_chain[TABLE_DEPTH];
    assign hit_flag  = |(here_vec & flag_vec);

    assign ctrl.exec  = exec_fire;
    assign ctrl.mode  = req_reg.mode;
    assign ctrl.key   = req_reg.card_id;
    assign ctrl.grant = req_reg.grant_access;
    assign ctrl.hit   = hit;
    assign ctrl.full  = full;

    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [cat_pkg::KEY_W-1:0] nkey;
        logic                      nflag;
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign nkey  = key_vec[i];
            assign nflag = flag_vec[i];
        end else begin : g_mid
            assign nkey  = key_vec[i+1];
            assign nflag = flag_vec[i+1];
        end
        cat_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (CNT_W'(i) < count_reg),
            .tail      (CNT_W'(i) == count_reg),
            .found_in  (found_chain[i]),
            .next_key  (nkey),
            .next_flag (nflag),
            .key_q     (key_vec[i]),
            .flag_q    (flag_vec[i]),
            .here      (here_vec[i]),
            .found_out (found_chain[i+1])
        );
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        count_ext    = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_fire) begin
                    state_next              = ST_IDLE;
                    m_valid_next            = 1'b1;
                    m_data_next.status      = cat_pkg::STATUS_OK;
                    m_data_next.card_access = 1'b0;
                    unique case (req_reg.mode)
                        cat_pkg::MODE_ADD: begin
                            if (hit) begin
                                m_data_next.card_access = req_reg.grant_access;
                            end else if (!full) begin
                                m_data_next.card_access = req_reg.grant_access;
                                count_next              = count_reg + CNT_W'(1);
                            end else begin
                                m_data_next.status = cat_pkg::STATUS_FULL;
                            end
                        end
                        cat_pkg::MODE_REMOVE: begin
                            if (hit) begin
                                count_next = count_reg - CNT_W'(1);
                            end else begin
                                m_data_next.status = cat_pkg::STATUS_ABSENT;
                            end
                        end
                        default: begin
                            // lookup, and the unused code
                            if (hit) begin
                                m_data_next.card_access = hit_flag;
                            end else begin
                                m_data_next.status = cat_pkg::STATUS_ABSENT;
                            end
                        end
                    endcase
                    count_ext               = 32'(count_next);
                    m_data_next.entry_count = count_ext[cat_pkg::COUNT_OUT_W-1:0];
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        m_data_reg <= m_data_next;
    end

    // keys are stored once only, so at most one cell can match
    a_unique_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(here_vec))
        else $error("more than one cell matches the request key");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> (count_reg == $past(count_reg))
                   || (count_reg == $past(count_reg) + CNT_W'(1))
                   || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("entry count moved by more than one");

    a_accept_then_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_valid && s_ready)
        else $error("update cycle did not leave a result");

endmodule
